// ===== rtl/fwtp_pkg.sv =====
// Shared types, constants and tree pseudo-LRU functions of the cache tag unit.
`timescale 1ns / 1ps
`default_nettype none
package fwtp_pkg;

    localparam int ADDR_W         = 64;
    localparam int SET_LSB        = 6;
    localparam int TAG_LSB        = 14;
    localparam int TAG_W          = 50;
    localparam int NUM_WAYS       = 4;
    localparam int WAY_W          = 2;
    localparam int TREE_W         = 3;
    localparam int TOTAL_W        = 32;
    localparam int DEF_SETS       = 256;
    localparam int DEF_COUNT_BITS = 32;

    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [WAY_W-1:0] t_way;
    typedef logic [TREE_W-1:0] t_tree;
    typedef t_tag [NUM_WAYS-1:0] t_tag_row;

    typedef struct packed {
        logic [NUM_WAYS-1:0] valid;
        t_tree               tree;
    } t_meta;

    typedef struct packed {
        logic  hit;
        t_way  way;
        t_meta meta;
    } t_result;

    // Tree bit 2 picks the pair, bit 1 the way within 0/1, bit 0 within 2/3.
    function automatic t_way plru_victim(input t_tree tree);
        t_way w;
        if (!tree[2]) begin
            w = tree[1] ? 2'd1 : 2'd0;
        end else begin
            w = tree[0] ? 2'd3 : 2'd2;
        end
        return w;
    endfunction

    function automatic t_tree plru_path(input t_way w);
        return w[1] ? 3'b101 : 3'b110;
    endfunction

    // Bits on the path after a reference, pointing away from the way.
    function automatic t_tree plru_away(input t_way w);
        t_tree v;
        unique case (w)
            2'd0:    v = 3'b110;
            2'd1:    v = 3'b100;
            2'd2:    v = 3'b001;
            default: v = 3'b000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fwtp_lookup.sv =====
// Four-way tag compare, victim choice and next set state for one access.
`timescale 1ns / 1ps
`default_nettype none
module fwtp_lookup (
    input  wire fwtp_pkg::t_meta    i_meta,
    input  wire fwtp_pkg::t_tag_row i_tags,
    input  wire fwtp_pkg::t_tag     i_tag,
    output fwtp_pkg::t_result       o_result
);
    import fwtp_pkg::*;

    logic [NUM_WAYS-1:0] match;
    logic                hit;
    t_way                hit_way;
    t_way                sel_way;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            match[w] = i_meta.valid[w] && (i_tags[w] == i_tag);
        end
    end

    always_comb begin
        hit     = |match;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        o_result.hit  = hit;
        o_result.meta = i_meta;
        if (hit) begin
            sel_way            = hit_way;
            o_result.meta.tree = (i_meta.tree & ~plru_path(hit_way)) | plru_away(hit_way);
        end else begin
            sel_way                      = plru_victim(i_meta.tree);
            o_result.meta.tree           = i_meta.tree ^ plru_path(sel_way);
            o_result.meta.valid[sel_way] = 1'b1;
        end
        o_result.way = sel_way;
    end

endmodule
`default_nettype wire

// ===== rtl/four_way_tree_plru_cache_tags_unit.sv =====
// Top level of the four-way tree pseudo-LRU cache tag unit.
`timescale 1ns / 1ps
`default_nettype none
// When SETS is a power of two, the set's metadata and tag rows are read from two
// synchronous memories in the cycle of acceptance; in state S_LOOK, once the output register
// is free or not stalled, the unit compares the four ways, writes the updated rows back and
// loads the result word into the output register. No new address is taken until that is
// done. For any other SETS the set is the line number (address bits 6 upward) modulo
// SETS, formed by a weighted fold of the line number at acceptance, then a reciprocal
// multiply, a remainder step and a final correction in states S_QUO, S_REM and S_FIX. After
// reset the unit clears the valid and tree bits of every set, one set per cycle, before
// the first address is accepted. The tag is always bits 14 to 63.
module four_way_tree_plru_cache_tags_unit #(
    parameter int SETS       = fwtp_pkg::DEF_SETS,
    parameter int COUNT_BITS = fwtp_pkg::DEF_COUNT_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire  [fwtp_pkg::ADDR_W-1:0]   i_in_address,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic                          o_out_hit,
    output logic [fwtp_pkg::WAY_W-1:0]    o_out_way,
    output logic [fwtp_pkg::TOTAL_W-1:0]  o_out_hit_total,
    output logic [fwtp_pkg::TOTAL_W-1:0]  o_out_miss_total
);
    import fwtp_pkg::*;

    localparam int SET_BITS   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam bit SETS_POW2  = ((SETS & (SETS - 1)) == 0);
    localparam int CHUNK_W    = 6;
    localparam int NUM_CHUNKS = (ADDR_W - SET_LSB + CHUNK_W - 1) / CHUNK_W;
    localparam int LINE_W     = NUM_CHUNKS * CHUNK_W;
    localparam int FOLD_W     = 22;
    localparam int REM_W      = SET_BITS + 1;
    localparam int RECIP      = (1 << FOLD_W) / SETS;

    // Weight of one chunk of the line number: 2 to the power of its bit position, modulo SETS.
    function automatic int fold_weight(input int idx);
        int w;
        w = 1 % SETS;
        for (int i = 0; i < idx; i++) begin
            w = (w * (1 << CHUNK_W)) % SETS;
        end
        return w;
    endfunction

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUO,
        S_REM,
        S_FIX,
        S_LOOK
    } t_state;

    t_state                r_state;
    logic [SET_BITS-1:0]   r_clr_idx;
    logic [SET_BITS-1:0]   r_set;
    t_tag                  r_tag;
    logic [FOLD_W-1:0]     r_sum;
    logic [FOLD_W-1:0]     r_quo;
    logic [REM_W-1:0]      r_rem;
    t_meta                 r_meta_rd;
    t_tag_row              r_tags_rd;
    logic                  r_out_valid;
    logic                  r_out_hit;
    t_way                  r_out_way;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic [COUNT_BITS-1:0] r_miss_cnt;

    t_meta    meta_mem [SETS];
    t_tag_row tag_mem  [SETS];

    logic                              in_acc;
    logic                              rd_en;
    logic                              lk_wr;
    logic                              clr_wr;
    logic [SET_BITS-1:0]               rd_set;
    t_result                           lk_res;
    t_tag_row                          tag_row_wr;
    logic [LINE_W-1:0]                 line_no;
    logic [NUM_CHUNKS-1:0][FOLD_W-1:0] fold_term;
    logic [FOLD_W-1:0]                 fold_sum;
    logic [2*FOLD_W-1:0]               quo_prod;
    logic [REM_W-1:0]                  rem_fix;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign lk_wr      = (r_state == S_LOOK) && (!r_out_valid || !i_out_stall);
    assign clr_wr     = (r_state == S_CLEAR);
    assign rd_en      = SETS_POW2 ? in_acc : (r_state == S_FIX);
    assign rd_set     = SETS_POW2 ? i_in_address[SET_LSB +: SET_BITS] : rem_fix[SET_BITS-1:0];

    assign line_no = LINE_W'(i_in_address[ADDR_W-1:SET_LSB]);

    for (genvar g = 0; g < NUM_CHUNKS; g++) begin : g_fold
        localparam int WEIGHT = fold_weight(g);
        assign fold_term[g] = FOLD_W'(line_no[g*CHUNK_W +: CHUNK_W]) * FOLD_W'(WEIGHT);
    end

    always_comb begin
        fold_sum = '0;
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            fold_sum = fold_sum + fold_term[c];
        end
    end

    assign quo_prod = (2*FOLD_W)'(r_sum) * (2*FOLD_W)'(RECIP);
    assign rem_fix  = (r_rem >= REM_W'(SETS)) ? r_rem - REM_W'(SETS) : r_rem;

    fwtp_lookup u_lookup (
        .i_meta   (r_meta_rd),
        .i_tags   (r_tags_rd),
        .i_tag    (r_tag),
        .o_result (lk_res)
    );

    always_comb begin
        tag_row_wr             = r_tags_rd;
        tag_row_wr[lk_res.way] = r_tag;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_meta_rd <= meta_mem[rd_set];
        end
        if (clr_wr) begin
            meta_mem[r_clr_idx] <= '0;
        end else if (lk_wr) begin
            meta_mem[r_set] <= lk_res.meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_tags_rd <= tag_mem[rd_set];
        end
        if (lk_wr && !lk_res.hit) begin
            tag_mem[r_set] <= tag_row_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
        end else begin
            if (lk_wr) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == SET_BITS'(SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_set <= rd_set;
                        r_tag <= i_in_address[TAG_LSB +: TAG_W];
                        r_sum <= fold_sum;
                        if (SETS_POW2) begin
                            r_state <= S_LOOK;
                        end else begin
                            r_state <= S_QUO;
                        end
                    end
                end
                S_QUO: begin
                    r_quo   <= quo_prod[2*FOLD_W-1:FOLD_W];
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_rem   <= REM_W'(r_sum - r_quo * FOLD_W'(SETS));
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_set   <= rd_set;
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (lk_wr) begin
                        r_out_hit <= lk_res.hit;
                        r_out_way <= lk_res.way;
                        if (lk_res.hit) begin
                            r_hit_cnt <= r_hit_cnt + 1'b1;
                        end else begin
                            r_miss_cnt <= r_miss_cnt + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_hit        = r_out_hit;
    assign o_out_way        = r_out_way;
    assign o_out_hit_total  = TOTAL_W'(r_hit_cnt);
    assign o_out_miss_total = TOTAL_W'(r_miss_cnt);

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !in_acc)
        else $error("Address accepted during the clearing pass.");

    a_result_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(lk_wr))
        else $error("Result word appeared without a lookup.");

    a_one_count_per_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lk_wr |=> ((r_hit_cnt + r_miss_cnt) == $past(r_hit_cnt + r_miss_cnt + 1'b1)))
        else $error("Hit and miss totals did not advance by one.");

    a_hit_way_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lk_wr && lk_res.hit) |-> r_meta_rd.valid[lk_res.way])
        else $error("Hit reported on an invalid way.");

endmodule
`default_nettype wire

// ===== verif/cache_tags_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts every lookup result word of the cache tag unit and compares it.
module cache_tags_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    input  wire                            i_in_stall,
    input  wire  [fwtp_pkg::ADDR_W-1:0]    i_in_address,
    input  wire                            i_out_valid,
    input  wire                            i_out_stall,
    input  wire                            i_out_hit,
    input  wire  [fwtp_pkg::WAY_W-1:0]     i_out_way,
    input  wire  [fwtp_pkg::TOTAL_W-1:0]   i_out_hit_total,
    input  wire  [fwtp_pkg::TOTAL_W-1:0]   i_out_miss_total,
    output int                             o_fail_count,
    output int                             o_pending
);
    import fwtp_pkg::*;

    localparam int SET_COUNT = DEF_SETS;

    typedef struct packed {
        logic               hit;
        t_way               way;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] miss_total;
    } lookup_word_t;

    logic               line_valid [SET_COUNT][NUM_WAYS];
    t_tag               line_tag [SET_COUNT][NUM_WAYS];
    t_tree              set_tree [SET_COUNT];
    logic [TOTAL_W-1:0] hits_seen;
    logic [TOTAL_W-1:0] misses_seen;
    lookup_word_t       expected_words [$];
    int                 failures = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic lookup_word_t predict_lookup(input logic [ADDR_W-1:0] addr);
        logic [TAG_LSB-SET_LSB-1:0] set_idx;
        t_tag                       tag;
        t_tree                      tree;
        t_way                       w;
        logic                       found;
        lookup_word_t               r;
        set_idx = addr[TAG_LSB-1:SET_LSB];
        tag = addr[ADDR_W-1:TAG_LSB];
        tree = set_tree[set_idx];
        found = 1'b0;
        w = '0;
        // Scanning downward leaves the lowest matching way selected.
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (line_valid[set_idx][i] && line_tag[set_idx][i] == tag) begin
                found = 1'b1;
                w = t_way'(i);
            end
        end
        if (found) begin
            tree[2] = ~w[1];
            if (w[1]) begin
                tree[0] = ~w[0];
            end else begin
                tree[1] = ~w[0];
            end
            hits_seen = hits_seen + 1'b1;
        end else begin
            w = tree[2] ? {1'b1, tree[0]} : {1'b0, tree[1]};
            tree[2] = ~tree[2];
            if (w[1]) begin
                tree[0] = ~tree[0];
            end else begin
                tree[1] = ~tree[1];
            end
            line_tag[set_idx][w] = tag;
            line_valid[set_idx][w] = 1'b1;
            misses_seen = misses_seen + 1'b1;
        end
        set_tree[set_idx] = tree;
        r.hit = found;
        r.way = w;
        r.hit_total = hits_seen;
        r.miss_total = misses_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        lookup_word_t exp_word;
        lookup_word_t got_word;
        if (!i_rst_n) begin
            for (int s = 0; s < SET_COUNT; s++) begin
                set_tree[s] = '0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    line_valid[s][w] = 1'b0;
                    line_tag[s][w] = '0;
                end
            end
            hits_seen = '0;
            misses_seen = '0;
            expected_words.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got_word.hit = i_out_hit;
                got_word.way = i_out_way;
                got_word.hit_total = i_out_hit_total;
                got_word.miss_total = i_out_miss_total;
                if (expected_words.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("unexpected result word: hit=%0d way=%0d hits=%0d misses=%0d",
                                 got_word.hit, got_word.way, got_word.hit_total,
                                 got_word.miss_total);
                    end
                end else begin
                    exp_word = expected_words.pop_front();
                    if (got_word.hit !== exp_word.hit || got_word.way !== exp_word.way ||
                        got_word.hit_total !== exp_word.hit_total ||
                        got_word.miss_total !== exp_word.miss_total) begin
                        failures++;
                        if (failures <= 10) begin
                            $display({"mismatch: expected hit=%0d way=%0d hits=%0d misses=%0d,",
                                      " got hit=%0d way=%0d hits=%0d misses=%0d"},
                                     exp_word.hit, exp_word.way, exp_word.hit_total,
                                     exp_word.miss_total, got_word.hit, got_word.way,
                                     got_word.hit_total, got_word.miss_total);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_words.push_back(predict_lookup(i_in_address));
            end
            o_pending <= expected_words.size();
        end
        o_fail_count <= failures;
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top that drives address words into the cache tag unit and reports the verdict.
module tb;
    import fwtp_pkg::*;

    localparam int RANDOM_WORDS = 450;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic [ADDR_W-1:0]    i_in_address = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_out_hit;
    logic [WAY_W-1:0]     o_out_way;
    logic [TOTAL_W-1:0]   o_out_hit_total;
    logic [TOTAL_W-1:0]   o_out_miss_total;
    int                   fail_count;
    int                   pending;

    t_tag                 tag_pool [8];
    logic [7:0]           hot_sets [4];

    four_way_tree_plru_cache_tags_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_address     (i_in_address),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_hit        (o_out_hit),
        .o_out_way        (o_out_way),
        .o_out_hit_total  (o_out_hit_total),
        .o_out_miss_total (o_out_miss_total)
    );

    cache_tags_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_in_address     (i_in_address),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_out_hit        (o_out_hit),
        .i_out_way        (o_out_way),
        .i_out_hit_total  (o_out_hit_total),
        .i_out_miss_total (o_out_miss_total),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #2_400_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int mode;
        int span;
        int phase;
        phase = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(30, 120);
            repeat (span) begin
                @(posedge i_clk);
                phase++;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 1) == 0);
                    default: i_out_stall <= (phase % 3 == 0);
                endcase
            end
        end
    end

    function automatic logic [ADDR_W-1:0] make_address(input t_tag tag, input logic [7:0] set_idx,
                                                       input logic [5:0] offset);
        return {tag, set_idx, offset};
    endfunction

    function automatic logic [ADDR_W-1:0] next_address();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            return {$urandom, $urandom};
        end else if (pick < 4) begin
            return make_address(tag_pool[$urandom_range(0, 7)], 8'($urandom_range(0, 255)),
                                6'($urandom_range(0, 63)));
        end
        return make_address(tag_pool[$urandom_range(0, 7)], hot_sets[$urandom_range(0, 3)],
                            6'($urandom_range(0, 63)));
    endfunction

    task automatic send_word(input logic [ADDR_W-1:0] addr);
        i_in_valid <= 1'b1;
        i_in_address <= addr;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] directed [$];
        logic [ADDR_W-1:0] rnd;
        t_tag              ta;
        t_tag              tb_tag;
        t_tag              tc;
        t_tag              td;
        t_tag              te;
        int                sent;
        int                burst;
        for (int i = 0; i < 8; i++) begin
            rnd = {$urandom, $urandom};
            tag_pool[i] = rnd[TAG_W-1:0];
        end
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        hot_sets[0] = 8'd0;
        hot_sets[1] = 8'd255;
        hot_sets[2] = 8'($urandom_range(1, 254));
        hot_sets[3] = 8'($urandom_range(1, 254));

        ta = 50'h1;
        tb_tag = 50'h2_AAAA_AAAA_AAAA;
        tc = 50'h1_5555_5555_5555;
        td = 50'h2_0000_0000_0000;
        te = 50'h3_FFFF_0000_FFFF;
        directed.push_back(make_address('0, 8'd0, 6'd0));
        directed.push_back('1);
        directed.push_back(make_address('1, 8'd255, 6'd0));
        directed.push_back(make_address('0, 8'd0, 6'd63));
        directed.push_back(make_address('0, 8'd1, 6'd0));
        directed.push_back(make_address(td, 8'd0, 6'd0));
        // Fill ways 0, 2 and 1 of one set, then steer the tree onto valid way 0
        // while way 3 is still invalid.
        directed.push_back(make_address(ta, 8'd5, 6'd0));
        directed.push_back(make_address(tb_tag, 8'd5, 6'd1));
        directed.push_back(make_address(tc, 8'd5, 6'd2));
        directed.push_back(make_address(tc, 8'd5, 6'd3));
        directed.push_back(make_address(tb_tag, 8'd5, 6'd4));
        directed.push_back(make_address(td, 8'd5, 6'd5));
        directed.push_back(make_address(ta, 8'd5, 6'd6));
        directed.push_back(make_address(td, 8'd5, 6'd7));
        directed.push_back(make_address(tb_tag, 8'd5, 6'd8));
        directed.push_back(make_address(tc, 8'd5, 6'd9));
        directed.push_back(make_address(ta, 8'd5, 6'd10));
        directed.push_back(make_address(te, 8'd5, 6'd11));
        directed.push_back(make_address(ta, 8'd5, 6'd12));
        directed.push_back(make_address(te, 8'd5, 6'd13));
        directed.push_back(make_address(td, 8'd5, 6'd14));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_word(directed[i]);
        end
        drain_results();

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < RANDOM_WORDS; j++) begin
                send_word(next_address());
                sent++;
            end
            if (sent >= RANDOM_WORDS / 2 && sent - burst < RANDOM_WORDS / 2) begin
                drain_results();
            end else if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        drain_results();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
